[hdl/stopwatch_countdown_timer_menu_defines.svh]
// Assertion macros for the stopwatch and countdown timer menu block.
`ifndef STOPWATCH_COUNTDOWN_TIMER_MENU_DEFINES_SVH
`define STOPWATCH_COUNTDOWN_TIMER_MENU_DEFINES_SVH

`ifndef ASSERT_OFF
// Implication or plain property checked at every clock edge outside reset.
`define STCM_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);
// Condition that must never be true outside reset.
`define STCM_NEVER(lbl, ck, rn, cond, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) else $error(msg);
`else
`define STCM_ASSERT(lbl, ck, rn, prop, msg)
`define STCM_NEVER(lbl, ck, rn, cond, msg)
`endif

`endif

[hdl/stcm_pkg.sv]
// Shared types and constants of the stopwatch and countdown timer menu block.
`default_nettype none
package stcm_pkg;

    localparam logic [1:0] MODE_MENU      = 2'd0;
    localparam logic [1:0] MODE_STOPWATCH = 2'd1;
    localparam logic [1:0] MODE_TIMER     = 2'd2;

    localparam logic [1:0] RUN_STOPPED = 2'd0;
    localparam logic [1:0] RUN_UP      = 2'd1;
    localparam logic [1:0] RUN_DOWN    = 2'd2;

    localparam logic [1:0] FIELD_SECONDS = 2'd0;
    localparam logic [1:0] FIELD_MINUTES = 2'd1;
    localparam logic [1:0] FIELD_HOURS   = 2'd2;
    localparam logic [1:0] FIELD_NONE    = 2'd3;

    localparam logic [5:0] SEXA_MAX  = 6'd59;
    localparam logic [6:0] HOURS_MAX = 7'd127;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 10;

    localparam logic [CFG_INDEX_W-1:0] REG_BUTTON_DIVIDE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TICK_DIVIDE   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_JOY_HIGH      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_JOY_LOW       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_LOW    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_HIGH   = 3'd5;

    localparam logic [7:0] BUTTON_DIVIDE_RST = 8'd2;
    localparam logic [7:0] TICK_DIVIDE_RST   = 8'd4;
    localparam logic [9:0] JOY_HIGH_RST      = 10'd900;
    localparam logic [9:0] JOY_LOW_RST       = 10'd200;
    localparam logic [9:0] CENTER_LOW_RST    = 10'd400;
    localparam logic [9:0] CENTER_HIGH_RST   = 10'd600;

    typedef struct packed {
        logic [7:0] button_divide;
        logic [7:0] tick_divide;
        logic [9:0] joy_high;
        logic [9:0] joy_low;
        logic [9:0] center_low;
        logic [9:0] center_high;
    } stcm_cfg_t;

    typedef struct packed {
        logic       last_select;
        logic       cursor;
        logic [1:0] mode;
        logic [1:0] run;
        logic [6:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [1:0] field;
        logic       pin;
    } stcm_state_t;

    // Register contents right after reset.
    localparam stcm_cfg_t CFG_RST = '{
        button_divide: BUTTON_DIVIDE_RST,
        tick_divide:   TICK_DIVIDE_RST,
        joy_high:      JOY_HIGH_RST,
        joy_low:       JOY_LOW_RST,
        center_low:    CENTER_LOW_RST,
        center_high:   CENTER_HIGH_RST
    };

    // The select line is taken as high out of reset; everything else starts cleared.
    localparam stcm_state_t STATE_RST = '{
        last_select: 1'b1,
        cursor:      1'b0,
        mode:        MODE_MENU,
        run:         RUN_STOPPED,
        hours:       7'd0,
        minutes:     6'd0,
        seconds:     6'd0,
        field:       FIELD_SECONDS,
        pin:         1'b0
    };

endpackage
`default_nettype wire

[hdl/stcm_button_scan.sv]
// Next-state logic for one acted-on button scan: cursor, mode and start/stop.
`default_nettype none
module stcm_button_scan (
    input  stcm_pkg::stcm_state_t state_cur,
    input  logic                  select_level,
    input  logic                  enter_n,
    input  logic                  startstop_n,
    output stcm_pkg::stcm_state_t state_new
);
    import stcm_pkg::*;

    logic enter;
    logic startstop;
    logic cursor_tgl;

    assign enter     = !enter_n;
    assign startstop = !startstop_n;

    always_comb
    begin
        state_new = state_cur;
        cursor_tgl = state_cur.cursor;
        if ((select_level != state_cur.last_select) && (state_cur.mode == MODE_MENU))
        begin
            cursor_tgl = !state_cur.cursor;
        end
        state_new.cursor      = cursor_tgl;
        state_new.last_select = select_level;

        priority if (enter && (state_cur.mode == MODE_MENU) && !cursor_tgl)
        begin
            state_new.mode = MODE_STOPWATCH;
        end
        else if (enter && (state_cur.mode == MODE_MENU))
        begin
            state_new.mode = MODE_TIMER;
        end
        else if (enter)
        begin
            // Return to the menu clears everything but the pin.
            state_new.mode    = MODE_MENU;
            state_new.run     = RUN_STOPPED;
            state_new.cursor  = 1'b0;
            state_new.field   = FIELD_SECONDS;
            state_new.hours   = '0;
            state_new.minutes = '0;
            state_new.seconds = '0;
        end
        else if ((state_cur.mode == MODE_STOPWATCH) && startstop)
        begin
            state_new.run = (state_cur.run == RUN_STOPPED) ? RUN_UP : RUN_STOPPED;
        end
        else if ((state_cur.mode == MODE_TIMER) && startstop)
        begin
            if (state_cur.run == RUN_STOPPED)
            begin
                state_new.run = RUN_DOWN;
                state_new.pin = 1'b0;
            end
            else
            begin
                state_new.run = RUN_STOPPED;
                state_new.pin = 1'b1;
            end
        end
        else
        begin
            state_new.mode = state_cur.mode;
        end
    end

endmodule
`default_nettype wire

[hdl/stcm_second_tick.sv]
// Next-state logic for one elapsed second: time counting and joystick editing.
`default_nettype none
module stcm_second_tick #(
    parameter int unsigned JOYSTICK_BITS = 10
) (
    input  stcm_pkg::stcm_state_t    state_cur,
    input  stcm_pkg::stcm_cfg_t      cfg,
    input  logic [JOYSTICK_BITS-1:0] joy_x,
    input  logic [JOYSTICK_BITS-1:0] joy_y,
    output stcm_pkg::stcm_state_t    state_new
);
    import stcm_pkg::*;

    // Compare width covers both the samples and the 10-bit thresholds.
    localparam int unsigned CW = (JOYSTICK_BITS > 10) ? JOYSTICK_BITS : 10;
    localparam logic [CW-1:0] JMASK = {CW{1'b1}} >> (CW - JOYSTICK_BITS);

    logic [CW-1:0] jh, jl, cl, ch, x, y;
    logic          edit, xc, yc;
    logic [6:0]    val;
    stcm_state_t   cnt;

    assign jh = CW'(cfg.joy_high) & JMASK;
    assign jl = CW'(cfg.joy_low) & JMASK;
    assign cl = CW'(cfg.center_low) & JMASK;
    assign ch = CW'(cfg.center_high) & JMASK;
    assign x  = CW'(joy_x);
    assign y  = CW'(joy_y);
    assign xc = (x > cl) && (x < ch);
    assign yc = (y > cl) && (y < ch);

    // Counting step.
    always_comb
    begin
        cnt = state_cur;
        if (state_cur.run == RUN_UP)
        begin
            if (state_cur.seconds >= SEXA_MAX)
            begin
                cnt.seconds = '0;
                if (state_cur.minutes >= SEXA_MAX)
                begin
                    cnt.minutes = '0;
                    if (state_cur.hours < HOURS_MAX)
                    begin
                        cnt.hours = state_cur.hours + 7'd1;
                    end
                end
                else
                begin
                    cnt.minutes = state_cur.minutes + 6'd1;
                end
            end
            else
            begin
                cnt.seconds = state_cur.seconds + 6'd1;
            end
        end
        else if (state_cur.run != RUN_STOPPED)
        begin
            if ((state_cur.seconds != '0) || (state_cur.minutes != '0)
                || (state_cur.hours != '0))
            begin
                if (state_cur.seconds == '0)
                begin
                    cnt.seconds = SEXA_MAX;
                    if (state_cur.minutes == '0)
                    begin
                        cnt.minutes = SEXA_MAX;
                        cnt.hours   = state_cur.hours - 7'd1;
                    end
                    else
                    begin
                        cnt.minutes = state_cur.minutes - 6'd1;
                    end
                end
                else
                begin
                    cnt.seconds = state_cur.seconds - 6'd1;
                end
            end
            else
            begin
                // Countdown already at zero: stop and raise the pin.
                cnt.run = RUN_STOPPED;
                cnt.pin = 1'b1;
            end
        end
    end

    assign edit = (cnt.mode == MODE_TIMER) && (cnt.run == RUN_STOPPED);

    // Joystick edits, each step seeing the one before it.
    always_comb
    begin
        state_new = cnt;
        if (edit && (y > jh) && xc && (state_new.field != FIELD_NONE))
        begin
            state_new.field = (state_new.field == FIELD_HOURS) ? FIELD_SECONDS
                                                               : state_new.field + 2'd1;
        end
        if (edit && (y < jl) && xc && (state_new.field != FIELD_NONE))
        begin
            state_new.field = (state_new.field == FIELD_SECONDS) ? FIELD_HOURS
                                                                 : state_new.field - 2'd1;
        end

        unique case (state_new.field)
            FIELD_SECONDS: val = {1'b0, state_new.seconds};
            FIELD_MINUTES: val = {1'b0, state_new.minutes};
            FIELD_HOURS:   val = state_new.hours;
            default:       val = '0;
        endcase

        if (edit && (x > jh) && yc && (state_new.field != FIELD_NONE)
            && (val < {1'b0, SEXA_MAX}))
        begin
            val = val + 7'd1;
        end
        if (edit && (x < jl) && yc && (state_new.field != FIELD_NONE) && (val != '0))
        begin
            val = val - 7'd1;
        end

        unique case (state_new.field)
            FIELD_SECONDS: state_new.seconds = val[5:0];
            FIELD_MINUTES: state_new.minutes = val[5:0];
            FIELD_HOURS:   state_new.hours   = val;
            default:       state_new.hours   = state_new.hours;
        endcase
    end

endmodule
`default_nettype wire

[hdl/stopwatch_countdown_timer_menu.sv]
// Top level of the stopwatch and countdown timer menu block.
// An accepted input beat is held in the input register, passes through the update logic
// and is registered again in the result register, which drives the result beat.
// One event per clock unless the result register is full and not read. It separates the
// two sides, so input beats keep flowing while it is full and read in the same cycle.
// Reset (rst_n low, asynchronous) clears all control, time and prescale state and
// loads the configuration registers with their default values.
`default_nettype none
`include "stopwatch_countdown_timer_menu_defines.svh"
module stopwatch_countdown_timer_menu #(
    parameter int unsigned JOYSTICK_BITS = 10
) (
    input  logic clk,
    input  logic rst_n,

    // Configuration write port.
    input  logic                                  cfg_we,
    input  logic [stcm_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [stcm_pkg::CFG_DATA_W-1:0]       cfg_data,

    // Event input stream.
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // tdata from bit 0: select_level, enter_n, startstop_n, joy_x, joy_y, zero fill.
    input  logic [((3+2*JOYSTICK_BITS+7)/8)*8-1:0] s_tdata,
    // tuser: operation (0 button scan, 1 time tick).
    input  logic                                  s_tuser,

    // Result output stream.
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // tdata from bit 0: mode[1:0], cursor[2], run_state[4:3], hours[11:5],
    // minutes[17:12], seconds[23:18], field_select[25:24], alarm_pin[26], zero fill.
    output logic [31:0]                           m_tdata
);
    import stcm_pkg::*;

    localparam int unsigned IN_W = ((3 + 2 * JOYSTICK_BITS + 7) / 8) * 8;

    // Configuration registers.
    stcm_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BUTTON_DIVIDE: cfg_reg.button_divide <= cfg_data[7:0];
                REG_TICK_DIVIDE:   cfg_reg.tick_divide   <= cfg_data[7:0];
                REG_JOY_HIGH:      cfg_reg.joy_high      <= cfg_data;
                REG_JOY_LOW:       cfg_reg.joy_low       <= cfg_data;
                REG_CENTER_LOW:    cfg_reg.center_low    <= cfg_data;
                REG_CENTER_HIGH:   cfg_reg.center_high   <= cfg_data;
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Input register. The stage moves on whenever the result register can take
    // a beat, which is when it is empty or being read in this cycle.
    logic            in_valid_reg;
    logic [IN_W-1:0] in_data_reg;
    logic            in_op_reg;
    logic            out_free;
    logic            advance;

    assign out_free = !m_tvalid || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata;
            in_op_reg   <= s_tuser;
        end
    end

    // Unpack the registered event.
    logic                     ev_select;
    logic                     ev_enter_n;
    logic                     ev_startstop_n;
    logic [JOYSTICK_BITS-1:0] ev_joy_x;
    logic [JOYSTICK_BITS-1:0] ev_joy_y;

    assign ev_select      = in_data_reg[0];
    assign ev_enter_n     = in_data_reg[1];
    assign ev_startstop_n = in_data_reg[2];
    assign ev_joy_x       = in_data_reg[3 +: JOYSTICK_BITS];
    assign ev_joy_y       = in_data_reg[3 + JOYSTICK_BITS +: JOYSTICK_BITS];

    // Prescalers: each event kind counts its own beats, and the event is acted
    // on once the count reaches the divide value. A divide of zero acts every time.
    logic [7:0] button_prescale_reg, button_prescale_next;
    logic [7:0] tick_prescale_reg, tick_prescale_next;
    logic [7:0] button_inc, tick_inc;
    logic       button_act, tick_act;

    assign button_inc = button_prescale_reg + 8'd1;
    assign tick_inc   = tick_prescale_reg + 8'd1;
    assign button_act = !in_op_reg && (button_inc >= cfg_reg.button_divide);
    assign tick_act   = in_op_reg && (tick_inc >= cfg_reg.tick_divide);

    always_comb
    begin
        button_prescale_next = button_prescale_reg;
        tick_prescale_next   = tick_prescale_reg;
        if (!in_op_reg)
        begin
            button_prescale_next = button_act ? 8'd0 : button_inc;
        end
        else
        begin
            tick_prescale_next = tick_act ? 8'd0 : tick_inc;
        end
    end

    // State update: one of the two event handlers, or no change.
    stcm_state_t state_reg, state_next;
    stcm_state_t button_state, tick_state;

    stcm_button_scan u_button_scan (
        .state_cur    (state_reg),
        .select_level (ev_select),
        .enter_n      (ev_enter_n),
        .startstop_n  (ev_startstop_n),
        .state_new    (button_state)
    );

    stcm_second_tick #(
        .JOYSTICK_BITS (JOYSTICK_BITS)
    ) u_second_tick (
        .state_cur (state_reg),
        .cfg       (cfg_reg),
        .joy_x     (ev_joy_x),
        .joy_y     (ev_joy_y),
        .state_new (tick_state)
    );

    always_comb
    begin
        priority if (button_act)
        begin
            state_next = button_state;
        end
        else if (tick_act)
        begin
            state_next = tick_state;
        end
        else
        begin
            state_next = state_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= STATE_RST;
            button_prescale_reg <= '0;
            tick_prescale_reg   <= '0;
        end
        else if (advance)
        begin
            state_reg           <= state_next;
            button_prescale_reg <= button_prescale_next;
            tick_prescale_reg   <= tick_prescale_next;
        end
    end

    // Result register: every event gives one result beat with the updated state.
    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            m_tvalid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_tdata_reg <= {5'd0, state_next.pin, state_next.field, state_next.seconds,
                            state_next.minutes, state_next.hours, state_next.run,
                            state_next.cursor, state_next.mode};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A countdown only ever runs in countdown mode, and the pin is low while it runs.
    `STCM_ASSERT(a_down_in_timer, clk, rst_n,
                 (state_reg.run == RUN_DOWN) |-> (state_reg.mode == MODE_TIMER),
                 "countdown running outside countdown mode")
    `STCM_ASSERT(a_pin_low_running, clk, rst_n,
                 (state_reg.run == RUN_DOWN) |-> !state_reg.pin,
                 "alarm pin high while countdown runs")
    // The menu always shows a cleared time with the count stopped.
    `STCM_ASSERT(a_menu_time_clear, clk, rst_n,
                 (state_reg.mode == MODE_MENU) |->
                     ((state_reg.hours == '0) && (state_reg.minutes == '0)
                      && (state_reg.seconds == '0) && (state_reg.run == RUN_STOPPED)),
                 "time not cleared in main menu")

endmodule
`default_nettype wire

[bench/stcm_result_checker.sv]
`timescale 1ns / 1ps
// Result checker of the stopwatch and countdown timer menu: predicts each result beat and compares it.
module stcm_result_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [stcm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [stcm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [23:0]                      s_tdata,
    input  logic                             s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [31:0]                      m_tdata,
    output int                               outstanding,
    output int                               fail_count
);
    import stcm_pkg::*;

    // Laid out so that a cast of m_tdata[26:0] lands every field in place.
    typedef struct packed {
        logic       pin;
        logic [1:0] field;
        logic [5:0] seconds;
        logic [5:0] minutes;
        logic [6:0] hours;
        logic [1:0] run;
        logic       cursor;
        logic [1:0] mode;
    } timer_view_t;

    logic [7:0] cfg_bdiv, cfg_tdiv;
    logic [9:0] cfg_jh, cfg_jl, cfg_cl, cfg_ch;

    logic [7:0] btn_count, tick_count;
    logic       sel_prev, cursor_q, pin_q;
    logic [1:0] mode_q, run_q, field_q;
    logic [6:0] hours_q;
    logic [5:0] mins_q, secs_q;

    timer_view_t expected_views[$];
    timer_view_t actual, want, next_view;
    int          mismatches = 0;
    int          results_seen = 0;
    int          pending_n = 0;

    assign fail_count  = mismatches;
    assign outstanding = pending_n;

    // Applies one event to the predicted state of the timer.
    task automatic advance_timer(input logic is_tick, input logic sel, input logic enter_n,
                                 input logic ss_n, input logic [9:0] jx, input logic [9:0] jy);
        logic       editing, x_mid, y_mid;
        logic [6:0] val;
        if (!is_tick) begin
            btn_count = btn_count + 8'd1;
            if (btn_count >= cfg_bdiv) begin
                btn_count = '0;
                if (sel != sel_prev && mode_q == MODE_MENU)
                    cursor_q = ~cursor_q;
                sel_prev = sel;
                if (!enter_n && mode_q == MODE_MENU) begin
                    mode_q = cursor_q ? MODE_TIMER : MODE_STOPWATCH;
                end else if (!enter_n) begin
                    // Back to the menu: everything but the pin is cleared.
                    mode_q   = MODE_MENU;
                    run_q    = RUN_STOPPED;
                    cursor_q = 1'b0;
                    field_q  = FIELD_SECONDS;
                    hours_q  = '0;
                    mins_q   = '0;
                    secs_q   = '0;
                end else if (mode_q == MODE_STOPWATCH && !ss_n) begin
                    run_q = (run_q == RUN_STOPPED) ? RUN_UP : RUN_STOPPED;
                end else if (mode_q == MODE_TIMER && !ss_n) begin
                    if (run_q == RUN_STOPPED) begin
                        run_q = RUN_DOWN;
                        pin_q = 1'b0;
                    end else begin
                        run_q = RUN_STOPPED;
                        pin_q = 1'b1;
                    end
                end
            end
        end else begin
            tick_count = tick_count + 8'd1;
            if (tick_count >= cfg_tdiv) begin
                tick_count = '0;
                if (run_q == RUN_UP) begin
                    if (secs_q == SEXA_MAX) begin
                        secs_q = '0;
                        if (mins_q == SEXA_MAX) begin
                            mins_q = '0;
                            if (hours_q != HOURS_MAX)
                                hours_q = hours_q + 7'd1;
                        end else begin
                            mins_q = mins_q + 6'd1;
                        end
                    end else begin
                        secs_q = secs_q + 6'd1;
                    end
                end else if (run_q != RUN_STOPPED) begin
                    if (secs_q != 0 || mins_q != 0 || hours_q != 0) begin
                        if (secs_q == 0) begin
                            secs_q = SEXA_MAX;
                            if (mins_q == 0) begin
                                mins_q  = SEXA_MAX;
                                hours_q = hours_q - 7'd1;
                            end else begin
                                mins_q = mins_q - 6'd1;
                            end
                        end else begin
                            secs_q = secs_q - 6'd1;
                        end
                    end else begin
                        run_q = RUN_STOPPED;
                        pin_q = 1'b1;
                    end
                end
                // Joystick edits see the run state left by the count above.
                editing = (mode_q == MODE_TIMER) && (run_q == RUN_STOPPED);
                x_mid   = (jx > cfg_cl) && (jx < cfg_ch);
                y_mid   = (jy > cfg_cl) && (jy < cfg_ch);
                if (editing && jy > cfg_jh && x_mid && field_q != FIELD_NONE)
                    field_q = (field_q == FIELD_HOURS) ? FIELD_SECONDS : field_q + 2'd1;
                if (editing && jy < cfg_jl && x_mid && field_q != FIELD_NONE)
                    field_q = (field_q == FIELD_SECONDS) ? FIELD_HOURS : field_q - 2'd1;
                if (editing && field_q != FIELD_NONE) begin
                    case (field_q)
                        FIELD_SECONDS: val = {1'b0, secs_q};
                        FIELD_MINUTES: val = {1'b0, mins_q};
                        default:       val = hours_q;
                    endcase
                    if (jx > cfg_jh && y_mid && val < 7'(SEXA_MAX))
                        val = val + 7'd1;
                    if (jx < cfg_jl && y_mid && val != 0)
                        val = val - 7'd1;
                    case (field_q)
                        FIELD_SECONDS: secs_q = val[5:0];
                        FIELD_MINUTES: mins_q = val[5:0];
                        default:       hours_q = val;
                    endcase
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_bdiv   = BUTTON_DIVIDE_RST;
            cfg_tdiv   = TICK_DIVIDE_RST;
            cfg_jh     = JOY_HIGH_RST;
            cfg_jl     = JOY_LOW_RST;
            cfg_cl     = CENTER_LOW_RST;
            cfg_ch     = CENTER_HIGH_RST;
            btn_count  = '0;
            tick_count = '0;
            sel_prev   = 1'b1;
            cursor_q   = 1'b0;
            mode_q     = MODE_MENU;
            run_q      = RUN_STOPPED;
            hours_q    = '0;
            mins_q     = '0;
            secs_q     = '0;
            field_q    = FIELD_SECONDS;
            pin_q      = 1'b0;
            expected_views.delete();
            pending_n <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_BUTTON_DIVIDE: cfg_bdiv = cfg_data[7:0];
                    REG_TICK_DIVIDE:   cfg_tdiv = cfg_data[7:0];
                    REG_JOY_HIGH:      cfg_jh   = cfg_data;
                    REG_JOY_LOW:       cfg_jl   = cfg_data;
                    REG_CENTER_LOW:    cfg_cl   = cfg_data;
                    REG_CENTER_HIGH:   cfg_ch   = cfg_data;
                    default: ;
                endcase
            end

            // A result can never belong to an event taken at the same edge, so
            // the oldest expectation is taken before a new one is added.
            if (m_tvalid && m_tready) begin
                actual = timer_view_t'(m_tdata[26:0]);
                if (expected_views.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result beat %h arrived with nothing expected", m_tdata);
                end else begin
                    want = expected_views.pop_front();
                    if (actual.mode !== want.mode || actual.cursor !== want.cursor ||
                        actual.run !== want.run || actual.hours !== want.hours ||
                        actual.minutes !== want.minutes || actual.seconds !== want.seconds ||
                        actual.field !== want.field || actual.pin !== want.pin ||
                        m_tdata[31:27] !== 5'd0) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("ERROR: result %0d expected mode=%0d cursor=%0d run=%0d %0d:%0d:%0d field=%0d pin=%0d",
                                     results_seen, want.mode, want.cursor, want.run, want.hours,
                                     want.minutes, want.seconds, want.field, want.pin);
                            $display("       actual   mode=%0d cursor=%0d run=%0d %0d:%0d:%0d field=%0d pin=%0d fill=%h",
                                     actual.mode, actual.cursor, actual.run, actual.hours,
                                     actual.minutes, actual.seconds, actual.field, actual.pin,
                                     m_tdata[31:27]);
                        end
                    end
                end
                results_seen++;
            end

            if (s_tvalid && s_tready) begin
                advance_timer(s_tuser, s_tdata[0], s_tdata[1], s_tdata[2],
                              s_tdata[12:3], s_tdata[22:13]);
                next_view.mode    = mode_q;
                next_view.cursor  = cursor_q;
                next_view.run     = run_q;
                next_view.hours   = hours_q;
                next_view.minutes = mins_q;
                next_view.seconds = secs_q;
                next_view.field   = field_q;
                next_view.pin     = pin_q;
                expected_views.push_back(next_view);
            end

            pending_n <= expected_views.size();
        end
    end

endmodule

[bench/tb_stopwatch_countdown_timer_menu.sv]
`timescale 1ns / 1ps
// Testbench top of the stopwatch and countdown timer menu: stimulus, flow control and verdict.
module tb_stopwatch_countdown_timer_menu;
    import stcm_pkg::*;

    // Event beat width for ten bit joystick samples: three button levels and two samples.
    localparam int DATA_W = ((3 + 2 * 10 + 7) / 8) * 8;
    // Stopwatch seconds with no gaps: enough to roll the seconds over into the minutes twice.
    localparam int STOPWATCH_SECONDS = 125;
    // Length of the long receiver hold-off, in cycles.
    localparam int HOLD_CYCLES = 300;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [DATA_W-1:0]      s_tdata;   // select_level, enter_n, startstop_n, joy_x, joy_y, zero fill
    logic                   s_tuser;   // operation: 0 button scan, 1 time tick
    logic                   m_tvalid;
    logic                   m_tready;
    logic [31:0]            m_tdata;   // mode, cursor, run_state, hours, minutes, seconds,
                                       // field_select, alarm_pin, zero fill
    int                     outstanding;
    int                     fail_count;

    // Idling switch for both sides, and the request for one long receiver hold-off.
    bit idle_on;
    bit hold_req;

    // Shadow of the configuration, used to pick joystick values near the thresholds
    // and to know how many events make one acted scan or one elapsed second.
    int bdiv_now, tdiv_now, jh_now, jl_now, cl_now, ch_now;

    // Select level of the random part; it is toggled now and then like a real button.
    logic sel_level;

    stopwatch_countdown_timer_menu u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    stcm_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // A hard stop well beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // Result side. Each pass makes exactly one drive of m_tready and then waits at
    // least one edge, so the ready line never gets two updates in one time step.
    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    function automatic logic [DATA_W-1:0] pack_event(input logic sel, input logic en_n,
                                                     input logic ss_n, input logic [9:0] jx,
                                                     input logic [9:0] jy);
        return {{(DATA_W - 23){1'b0}}, jy, jx, ss_n, en_n, sel};
    endfunction

    // Joystick sample that lands near the thresholds most of the time, so that the
    // edges of the pushed and centered bands get hit as well as their insides.
    function automatic logic [9:0] axis_sample();
        case ($urandom_range(0, 4))
            0:       return 10'($urandom_range(0, jl_now));
            1:       return 10'($urandom_range(jh_now, 1023));
            2:       return 10'($urandom_range(cl_now, ch_now));
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    // Offers one event beat and returns at the edge where it is taken. Valid stays
    // high into the next beat unless an idle burst is drawn.
    task automatic send_beat(input logic op, input logic [DATA_W-1:0] data);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // One acted button scan: as many button events as the divider asks for, all
    // with the same levels, with noise on the joystick fields.
    task automatic scan(input logic sel, input logic en_n, input logic ss_n);
        repeat ((bdiv_now == 0) ? 1 : bdiv_now)
            send_beat(1'b0, pack_event(sel, en_n, ss_n, 10'($urandom), 10'($urandom)));
    endtask

    // A number of elapsed seconds with a fixed joystick position and noise on the buttons.
    task automatic seconds_pass(input int jx, input int jy, input int count);
        repeat (count * ((tdiv_now == 0) ? 1 : tdiv_now))
            send_beat(1'b1, pack_event(1'($urandom), 1'($urandom), 1'($urandom),
                                       10'(jx), 10'(jy)));
    endtask

    // Stops offering beats and waits until every expected result has come out.
    // The first edge lets the checker count the beat that was just taken.
    task automatic wait_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        @(posedge clk);
        case (idx)
            REG_BUTTON_DIVIDE: bdiv_now = val;
            REG_TICK_DIVIDE:   tdiv_now = val;
            REG_JOY_HIGH:      jh_now   = val;
            REG_JOY_LOW:       jl_now   = val;
            REG_CENTER_LOW:    cl_now   = val;
            REG_CENTER_HIGH:   ch_now   = val;
            default: ;
        endcase
    endtask

    // Writes all six registers while the block has nothing in flight.
    task automatic load_setting(input int bd, input int td, input int jh, input int jl,
                                input int cl, input int ch);
        wait_results();
        write_reg(REG_BUTTON_DIVIDE, bd);
        write_reg(REG_TICK_DIVIDE, td);
        write_reg(REG_JOY_HIGH, jh);
        write_reg(REG_JOY_LOW, jl);
        write_reg(REG_CENTER_LOW, cl);
        write_reg(REG_CENTER_HIGH, ch);
        cfg_we <= 1'b0;
    endtask

    // Random events. Enter is rare so that a mode lasts long enough for counts,
    // edits and countdowns to zero to happen; start/stop comes more often.
    task automatic random_beat();
        logic op;
        op = ($urandom_range(0, 99) < 55);
        if ($urandom_range(0, 3) == 0)
            sel_level = ~sel_level;
        send_beat(op, pack_event(sel_level, $urandom_range(0, 99) >= 4,
                                 $urandom_range(0, 99) >= 12, axis_sample(), axis_sample()));
    endtask

    task automatic run_phase(input int bd, input int td, input int jh, input int jl,
                             input int cl, input int ch, input int beats,
                             input bit idle, input bit squeeze);
        load_setting(bd, td, jh, jl, cl, ch);
        idle_on = idle;
        for (int i = 0; i < beats; i++)
        begin
            // The receiver stops for a long while here and the sender keeps offering,
            // so the block fills up and has to hold its input back.
            if (squeeze && i == 40)
                hold_req = 1'b1;
            random_beat();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tuser   <= 1'b0;
        s_tdata   <= '0;
        idle_on   = 1'b1;
        hold_req  = 1'b0;
        sel_level = 1'b1;
        bdiv_now  = int'(BUTTON_DIVIDE_RST);
        tdiv_now  = int'(TICK_DIVIDE_RST);
        jh_now    = int'(JOY_HIGH_RST);
        jl_now    = int'(JOY_LOW_RST);
        cl_now    = int'(CENTER_LOW_RST);
        ch_now    = int'(CENTER_HIGH_RST);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the reset configuration: two button events per scan and
        // four ticks per second. The select line comes out of reset high.
        scan(1'b1, 1'b1, 1'b1);     // nothing pressed, nothing changes
        scan(1'b0, 1'b1, 1'b1);     // select change in the menu moves the cursor down
        scan(1'b1, 1'b1, 1'b1);     // and back up
        scan(1'b1, 1'b1, 1'b0);     // start/stop means nothing in the menu
        scan(1'b1, 1'b0, 1'b1);     // enter on the first line opens the stopwatch
        scan(1'b1, 1'b1, 1'b0);     // start counting up
        seconds_pass(500, 500, 1);
        scan(1'b0, 1'b1, 1'b1);     // select change outside the menu leaves the cursor
        scan(1'b0, 1'b0, 1'b0);     // enter and start/stop together: enter wins, back to menu

        // Divider of zero acts on every event. The stopwatch then runs with no gaps
        // through two rollovers of the seconds into the minutes.
        load_setting(1, 0, int'(JOY_HIGH_RST), int'(JOY_LOW_RST),
                     int'(CENTER_LOW_RST), int'(CENTER_HIGH_RST));
        scan(1'b0, 1'b0, 1'b1);
        scan(1'b0, 1'b1, 1'b0);
        idle_on = 1'b0;
        seconds_pass(500, 500, STOPWATCH_SECONDS);
        idle_on = 1'b1;
        scan(1'b0, 1'b0, 1'b1);     // back to the menu clears the time

        // Countdown mode and the joystick editor.
        scan(1'b1, 1'b1, 1'b1);     // cursor to the timer line
        scan(1'b1, 1'b0, 1'b1);     // open the countdown timer
        seconds_pass(1000, 500, 61); // seconds step up and stop at 59
        seconds_pass(500, 1000, 1);  // next field: minutes
        seconds_pass(500, 100, 2);   // previous field twice: seconds, then wrap to hours
        seconds_pass(1000, 500, 1);  // one hour
        seconds_pass(500, 1000, 1);  // next field wraps from hours to seconds
        seconds_pass(100, 500, 60);  // seconds down to zero, then no further
        scan(1'b1, 1'b1, 1'b0);      // start the countdown at 1:00:00, the pin goes low
        seconds_pass(500, 500, 1);   // borrow through minutes and hours
        scan(1'b1, 1'b1, 1'b0);      // stop it, the pin goes high
        seconds_pass(500, 100, 1);   // to hours
        seconds_pass(100, 500, 1);   // hours to zero
        seconds_pass(100, 500, 1);   // and no lower
        seconds_pass(500, 100, 1);   // to minutes
        seconds_pass(100, 500, 59);
        seconds_pass(500, 100, 1);   // to seconds
        seconds_pass(100, 500, 57);  // 00:00:02 left
        scan(1'b1, 1'b1, 1'b0);
        seconds_pass(500, 500, 2);
        // At zero the countdown stops and raises the pin; the joystick edit acts
        // on that same second.
        seconds_pass(1000, 500, 1);

        // Random part over several settings. Reset values first, then bands that
        // overlap so that a field step and a value step happen on one tick, then the
        // extremes of every register, and a last stretch with no idling at all.
        run_phase(int'(BUTTON_DIVIDE_RST), int'(TICK_DIVIDE_RST), int'(JOY_HIGH_RST),
                  int'(JOY_LOW_RST), int'(CENTER_LOW_RST), int'(CENTER_HIGH_RST),
                  250, 1'b1, 1'b0);
        run_phase(1, 1, 700, 300, 100, 1000, 300, 1'b1, 1'b1);
        run_phase(0, 0, 1023, 0, 0, 1023, 200, 1'b1, 1'b0);
        run_phase(255, 255, 0, 1023, 1023, 0, 250, 1'b1, 1'b0);
        run_phase(1, 2, 512, 511, 300, 800, 250, 1'b0, 1'b0);

        wait_results();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
